// File: sv/linear_ode_integrator_step_macros.svh
// ----------------------------------------------------------------------------
// Linear ODE integrator step - assertion macros
// Property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ODE_INTEGRATOR_STEP_MACROS_SVH
`define LINEAR_ODE_INTEGRATOR_STEP_MACROS_SVH

// same-cycle implication
`define LODE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lode: same-cycle check failed");

// next-cycle implication
`define LODE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lode: next-cycle check failed");

`endif

// File: sv/lode_pkg.sv
// ----------------------------------------------------------------------------
// Linear ODE integrator step - package
// Widths, fixed-point limits, register and method codes, shared structs.
// ----------------------------------------------------------------------------
package lode_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int COEF_FRAC_BITS = 24;

    localparam int DRIVE_W   = 32;
    localparam int STATE_W   = 32;
    localparam int REG_W     = 32;
    localparam int DT_W      = 31;
    localparam int METHOD_W  = 2;
    localparam int CFG_IDX_W = 4;

    localparam int COEF_W  = REG_W + 1;
    localparam int PROD_W  = COEF_W + DATA_WIDTH;
    localparam int QT_W    = PROD_W + 1 - COEF_FRAC_BITS;
    localparam int DIG_W   = 8;
    localparam int REM_W   = 3;
    localparam int DIV_STEPS = (QT_W + DIG_W - 1) / DIG_W;
    localparam int QUO_W     = DIV_STEPS * DIG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DEXT_W    = (DATA_WIDTH > DRIVE_W) ? DATA_WIDTH : DRIVE_W;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic        [DATA_WIDTH-1:0] t_mag;
    typedef logic signed [COEF_W-1:0]     t_coef;
    typedef logic signed [PROD_W-1:0]     t_prod;

    localparam t_data DMAX    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DMIN    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_mag  MAG_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_mag  MAG_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [REM_W-1:0] DIVISOR_SIX = REM_W'(6);

    localparam logic [METHOD_W-1:0] METH_EULER = 2'd0;
    localparam logic [METHOD_W-1:0] METH_HEUN  = 2'd1;
    localparam logic [METHOD_W-1:0] METH_RK4   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD  = 4'd3;

    localparam logic [DT_W-1:0] DT_ONE = DT_W'(32'd1 << COEF_FRAC_BITS);

    typedef struct packed {
        logic signed [REG_W-1:0] coef_a;
        logic signed [REG_W-1:0] coef_b;
        logic [DT_W-1:0]         step_dt;
        logic [METHOD_W-1:0]     method;
    } t_cfg;

    typedef struct packed {
        logic  start;
        logic  use_mul;
        logic  half;
        logic  div6;
        t_coef coef;
        t_data val;
        t_data addend;
    } t_op_req;

    typedef struct packed {
        logic  done;
        logic  ovf;
        t_data value;
    } t_op_rsp;

    typedef struct packed {
        logic  go;
        logic  clamp;
        t_data u;
    } t_item;

    typedef struct packed {
        logic  idle;
        logic  done;
        logic  flag;
        t_data x;
    } t_seq_stat;

endpackage

// File: sv/lode_unit.sv
// ----------------------------------------------------------------------------
// Linear ODE integrator step - shared arithmetic unit
// Optional multiply, round with optional halving, optional divide by six, saturate, then saturating add.
// ----------------------------------------------------------------------------
module lode_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lode_pkg::t_op_req i_req,
    output lode_pkg::t_op_rsp o_rsp
);
    import lode_pkg::*;

    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_MUL  = 6'b000010,
        U_RND  = 6'b000100,
        U_DIV  = 6'b001000,
        U_CLIP = 6'b010000,
        U_ADD  = 6'b100000
    } t_ustate;

    t_ustate r_state, n_state;

    logic                 r_half, n_half;
    logic                 r_div6, n_div6;
    t_coef                r_coef, n_coef;
    t_data                r_val, n_val;
    t_data                r_addend, n_addend;
    t_prod                r_prod, n_prod;
    logic [QUO_W-1:0]     r_q, n_q;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_mag                 r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic                 r_movf, n_movf;

    logic                      w_neg;
    logic [PROD_W-1:0]         w_pmag;
    logic [REM_W-1:0]          w_rbase;
    logic [PROD_W:0]           w_rnd;
    logic [PROD_W:0]           w_sum;
    logic [QT_W-1:0]           w_t;
    t_mag                      w_lim_r;
    t_mag                      w_lim_c;
    logic                      w_sat_r;
    logic                      w_sat_c;
    logic [DIG_W-1:0]          w_digit;
    logic [REM_W-1:0]          w_rem;
    logic signed [DATA_WIDTH:0]   w_mext;
    logic signed [DATA_WIDTH:0]   w_m;
    logic signed [DATA_WIDTH+1:0] w_s;
    logic                      w_hi;
    logic                      w_lo;

    // round and scale the product magnitude
    assign w_neg   = r_prod[PROD_W-1];
    assign w_pmag  = w_neg ? $unsigned(-r_prod) : $unsigned(r_prod);
    assign w_rbase = r_div6 ? DIVISOR_SIX : REM_W'(1);
    assign w_rnd   = r_half ? ((PROD_W+1)'(w_rbase) << COEF_FRAC_BITS)
                            : ((PROD_W+1)'(w_rbase) << (COEF_FRAC_BITS - 1));
    assign w_sum   = (PROD_W+1)'(w_pmag) + w_rnd;
    assign w_t     = r_half ? QT_W'(w_sum >> (COEF_FRAC_BITS + 1))
                            : QT_W'(w_sum >> COEF_FRAC_BITS);
    assign w_lim_r = w_neg ? MAG_NEG : MAG_POS;
    assign w_sat_r = w_t > QT_W'(w_lim_r);
    assign w_lim_c = r_neg ? MAG_NEG : MAG_POS;
    assign w_sat_c = r_q > QUO_W'(w_lim_c);

    // one quotient digit group per cycle, divisor six
    always_comb begin : div_digits
        logic [REM_W:0]   cur;
        logic [REM_W-1:0] rem;
        rem     = r_rem;
        cur     = '0;
        w_digit = '0;
        for (int i = 0; i < DIG_W; i++) begin
            cur = {rem, r_q[QUO_W-1-i]};
            if (cur >= (REM_W+1)'(DIVISOR_SIX)) begin
                w_digit[DIG_W-1-i] = 1'b1;
                rem = REM_W'(cur - (REM_W+1)'(DIVISOR_SIX));
            end else begin
                rem = cur[REM_W-1:0];
            end
        end
        w_rem = rem;
    end

    // signed product term plus addend, clamp to data range
    assign w_mext = $signed({1'b0, r_mag});
    assign w_m    = r_neg ? -w_mext : w_mext;
    assign w_s    = (DATA_WIDTH+2)'(w_m) + (DATA_WIDTH+2)'(r_addend);
    assign w_hi   = w_s > (DATA_WIDTH+2)'(DMAX);
    assign w_lo   = w_s < (DATA_WIDTH+2)'(DMIN);

    assign o_rsp.done  = (r_state == U_ADD);
    assign o_rsp.ovf   = r_movf | w_hi | w_lo;
    assign o_rsp.value = w_hi ? DMAX : (w_lo ? DMIN : DATA_WIDTH'(w_s));

    always_comb begin
        n_state  = r_state;
        n_half   = r_half;
        n_div6   = r_div6;
        n_coef   = r_coef;
        n_val    = r_val;
        n_addend = r_addend;
        n_prod   = r_prod;
        n_q      = r_q;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_movf   = r_movf;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_half   = i_req.half;
                    n_div6   = i_req.div6;
                    n_coef   = i_req.coef;
                    n_val    = i_req.val;
                    n_addend = i_req.addend;
                    n_neg    = i_req.val[DATA_WIDTH-1];
                    n_mag    = i_req.val[DATA_WIDTH-1] ? t_mag'(-i_req.val)
                                                       : t_mag'(i_req.val);
                    n_movf   = 1'b0;
                    n_state  = i_req.use_mul ? U_MUL : U_ADD;
                end
            end
            U_MUL: begin
                n_prod  = r_coef * r_val;
                n_state = U_RND;
            end
            U_RND: begin
                n_neg = w_neg;
                if (r_div6) begin
                    n_q     = QUO_W'(w_t);
                    n_rem   = '0;
                    n_cnt   = DIV_CNT_W'(DIV_STEPS - 1);
                    n_state = U_DIV;
                end else begin
                    n_mag   = w_sat_r ? w_lim_r : t_mag'(w_t);
                    n_movf  = w_sat_r;
                    n_state = U_ADD;
                end
            end
            U_DIV: begin
                n_q   = {r_q[QUO_W-DIG_W-1:0], w_digit};
                n_rem = w_rem;
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = U_CLIP;
                end
            end
            U_CLIP: begin
                n_mag   = w_sat_c ? w_lim_c : t_mag'(r_q);
                n_movf  = w_sat_c;
                n_state = U_ADD;
            end
            U_ADD: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_half   <= n_half;
        r_div6   <= n_div6;
        r_coef   <= n_coef;
        r_val    <= n_val;
        r_addend <= n_addend;
        r_prod   <= n_prod;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_movf   <= n_movf;
    end

endmodule

// File: sv/lode_seq.sv
// ----------------------------------------------------------------------------
// Linear ODE integrator step - sequencer
// Walks the Euler, Heun or RK4 stages through the shared arithmetic unit.
// ----------------------------------------------------------------------------
module lode_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lode_pkg::t_cfg      i_cfg,
    input  lode_pkg::t_item     i_item,
    input  logic                i_out_free,
    input  lode_pkg::t_op_rsp   i_rsp,
    output lode_pkg::t_op_req   o_req,
    output lode_pkg::t_seq_stat o_stat
);
    import lode_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_BU   = 17'h00002,
        S_K1   = 17'h00004,
        S_Y1   = 17'h00008,
        S_K2   = 17'h00010,
        S_HS   = 17'h00020,
        S_Y2   = 17'h00040,
        S_K3   = 17'h00080,
        S_Y3   = 17'h00100,
        S_K4   = 17'h00200,
        S_T2   = 17'h00400,
        S_A2   = 17'h00800,
        S_T3   = 17'h01000,
        S_A3   = 17'h02000,
        S_A4   = 17'h04000,
        S_XN   = 17'h08000,
        S_DONE = 17'h10000
    } t_sstate;

    t_sstate r_state, n_state;
    logic    r_issued, n_issued;
    logic    r_flag, n_flag;
    t_data   r_x, n_x;
    t_data   r_u, n_u;
    t_data   r_bu, n_bu;
    t_data   r_k1, n_k1;
    t_data   r_k2, n_k2;
    t_data   r_k3, n_k3;
    t_data   r_y, n_y;
    t_data   r_t, n_t;
    t_data   r_sum, n_sum;

    t_coef   w_ca;
    t_coef   w_cb;
    t_coef   w_dt;
    logic    w_rk4;
    logic    w_heun;
    t_op_req w_req;

    assign w_ca   = COEF_W'($signed(i_cfg.coef_a));
    assign w_cb   = COEF_W'($signed(i_cfg.coef_b));
    assign w_dt   = COEF_W'($signed({1'b0, i_cfg.step_dt}));
    assign w_rk4  = (i_cfg.method == METH_RK4);
    assign w_heun = (i_cfg.method == METH_HEUN);

    always_comb begin
        w_req       = '0;
        w_req.start = !r_issued && (r_state != S_IDLE) && (r_state != S_DONE);
        case (r_state)
            S_BU: begin
                w_req.use_mul = 1'b1;
                w_req.coef    = w_cb;
                w_req.val     = r_u;
            end
            S_K1: begin
                w_req.use_mul = 1'b1;
                w_req.coef    = w_ca;
                w_req.val     = r_x;
                w_req.addend  = r_bu;
            end
            S_Y1: begin
                w_req.use_mul = 1'b1;
                w_req.half    = w_rk4;
                w_req.coef    = w_dt;
                w_req.val     = r_k1;
                w_req.addend  = r_x;
            end
            S_K2, S_K3, S_K4: begin
                w_req.use_mul = 1'b1;
                w_req.coef    = w_ca;
                w_req.val     = r_y;
                w_req.addend  = r_bu;
            end
            S_HS: begin
                w_req.val    = r_k1;
                w_req.addend = r_k2;
            end
            S_Y2: begin
                w_req.use_mul = 1'b1;
                w_req.half    = 1'b1;
                w_req.coef    = w_dt;
                w_req.val     = r_k2;
                w_req.addend  = r_x;
            end
            S_Y3: begin
                w_req.use_mul = 1'b1;
                w_req.coef    = w_dt;
                w_req.val     = r_k3;
                w_req.addend  = r_x;
            end
            S_T2: begin
                w_req.val    = r_k2;
                w_req.addend = r_k2;
            end
            S_A2: begin
                w_req.val    = r_k1;
                w_req.addend = r_t;
            end
            S_T3: begin
                w_req.val    = r_k3;
                w_req.addend = r_k3;
            end
            S_A3: begin
                w_req.val    = r_sum;
                w_req.addend = r_t;
            end
            S_A4: begin
                w_req.val    = r_sum;
                w_req.addend = r_y;
            end
            S_XN: begin
                w_req.use_mul = 1'b1;
                w_req.half    = !w_rk4;
                w_req.div6    = w_rk4;
                w_req.coef    = w_dt;
                w_req.val     = r_sum;
                w_req.addend  = r_x;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    assign o_req = w_req;

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_flag   = r_flag;
        n_x      = r_x;
        n_u      = r_u;
        n_bu     = r_bu;
        n_k1     = r_k1;
        n_k2     = r_k2;
        n_k3     = r_k3;
        n_y      = r_y;
        n_t      = r_t;
        n_sum    = r_sum;
        case (r_state)
            S_IDLE: begin
                if (i_item.go) begin
                    n_u     = i_item.u;
                    n_flag  = i_item.clamp;
                    n_state = S_BU;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                if (w_req.start) begin
                    n_issued = 1'b1;
                end
                if (i_rsp.done) begin
                    n_issued = 1'b0;
                    n_flag   = r_flag | i_rsp.ovf;
                    case (r_state)
                        S_BU: begin
                            n_bu    = i_rsp.value;
                            n_state = S_K1;
                        end
                        S_K1: begin
                            n_k1    = i_rsp.value;
                            n_state = S_Y1;
                        end
                        S_Y1: begin
                            if (w_rk4 || w_heun) begin
                                n_y     = i_rsp.value;
                                n_state = S_K2;
                            end else begin
                                n_x     = i_rsp.value;
                                n_state = S_DONE;
                            end
                        end
                        S_K2: begin
                            n_k2    = i_rsp.value;
                            n_state = w_heun ? S_HS : S_Y2;
                        end
                        S_HS: begin
                            n_sum   = i_rsp.value;
                            n_state = S_XN;
                        end
                        S_Y2: begin
                            n_y     = i_rsp.value;
                            n_state = S_K3;
                        end
                        S_K3: begin
                            n_k3    = i_rsp.value;
                            n_state = S_Y3;
                        end
                        S_Y3: begin
                            n_y     = i_rsp.value;
                            n_state = S_K4;
                        end
                        S_K4: begin
                            n_y     = i_rsp.value;
                            n_state = S_T2;
                        end
                        S_T2: begin
                            n_t     = i_rsp.value;
                            n_state = S_A2;
                        end
                        S_A2: begin
                            n_sum   = i_rsp.value;
                            n_state = S_T3;
                        end
                        S_T3: begin
                            n_t     = i_rsp.value;
                            n_state = S_A3;
                        end
                        S_A3: begin
                            n_sum   = i_rsp.value;
                            n_state = S_A4;
                        end
                        S_A4: begin
                            n_sum   = i_rsp.value;
                            n_state = S_XN;
                        end
                        S_XN: begin
                            n_x     = i_rsp.value;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE) && i_out_free;
    assign o_stat.flag = r_flag;
    assign o_stat.x    = r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_x      <= '0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_x      <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flag <= n_flag;
        r_u    <= n_u;
        r_bu   <= n_bu;
        r_k1   <= n_k1;
        r_k2   <= n_k2;
        r_k3   <= n_k3;
        r_y    <= n_y;
        r_t    <= n_t;
        r_sum  <= n_sum;
    end

endmodule

// File: sv/linear_ode_integrator_step.sv
// ----------------------------------------------------------------------------
// Linear ODE integrator step - top level
// One item at a time; the next is taken the cycle after the result is registered.
// The shared multiply/round/add unit sets the pace: a product passes its multiply,
// round and add states, a sum only the add state, and the final RK4 product also
// the divide and clip states for its divide by six. Synchronous active-low reset
// clears the state to zero, coefficients to zero, dt to 1.0, method to Euler.
// ----------------------------------------------------------------------------
module linear_ode_integrator_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lode_pkg::DRIVE_W-1:0]     s_axis_tdata,  // [31:0] drive_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lode_pkg::STATE_W-1:0]     m_axis_tdata,  // [31:0] state_out
    output logic                             m_axis_tuser,  // [0] saturated
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lode_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lode_pkg::REG_W-1:0]       i_cfg_data
);
    import lode_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_data     r_out_x;
    logic      r_out_sat;

    logic signed [DEXT_W-1:0] w_dext;
    logic      w_dhi;
    logic      w_dlo;
    t_item     w_item;
    logic      w_out_free;
    t_op_req   w_req;
    t_op_rsp   w_rsp;
    t_seq_stat w_stat;

    // clamp the drive into the data range
    assign w_dext = DEXT_W'($signed(s_axis_tdata));
    assign w_dhi  = w_dext > DEXT_W'(DMAX);
    assign w_dlo  = w_dext < DEXT_W'(DMIN);

    assign w_item.go    = s_axis_tvalid && s_axis_tready;
    assign w_item.clamp = w_dhi || w_dlo;
    assign w_item.u     = w_dhi ? DMAX : (w_dlo ? DMIN : DATA_WIDTH'(w_dext));

    assign s_axis_tready = w_stat.idle;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a  <= '0;
            r_cfg.coef_b  <= '0;
            r_cfg.step_dt <= DT_ONE;
            r_cfg.method  <= METH_EULER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COEF_A:  r_cfg.coef_a  <= i_cfg_data;
                REG_COEF_B:  r_cfg.coef_b  <= i_cfg_data;
                REG_STEP_DT: r_cfg.step_dt <= i_cfg_data[DT_W-1:0];
                REG_METHOD:  r_cfg.method  <= i_cfg_data[METHOD_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the result until the output transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out_x   <= w_stat.x;
            r_out_sat <= w_stat.flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = STATE_W'(r_out_x);
    assign m_axis_tuser  = r_out_sat;

    lode_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .i_rsp      (w_rsp),
        .o_req      (w_req),
        .o_stat     (w_stat)
    );

    lode_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

endmodule

// File: sv/lode_checker.sv
// ----------------------------------------------------------------------------
// Linear ODE integrator step - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "linear_ode_integrator_step_macros.svh"

module lode_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lode_pkg::STATE_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);

    `LODE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `LODE_ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

    `LODE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind linear_ode_integrator_step lode_checker u_lode_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
